>>> rtl/core/packet_rule_filter_assert.svh
// Assertion macros used by the top RTL file of the packet rule filter.
`ifndef PACKET_RULE_FILTER_ASSERT_SVH
`define PACKET_RULE_FILTER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define PRF_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define PRF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/prf_pkg.sv
package prf_pkg;

   localparam int OffsetBits  = 11;
   localparam int PatternMax  = 8;
   localparam int PayEndBits  = 17;
   localparam int CfgAddrBits = 6;
   localparam int CfgDataBits = 64;

   localparam logic [7:0]  EthHdrLen = 8'd14;
   localparam logic [11:0] VlanMask  = 12'h0FFF;
   localparam logic [7:0]  ProtoTcp  = 8'd6;
   localparam logic [7:0]  ProtoUdp  = 8'd17;
   localparam logic [7:0]  ProtoIcmp = 8'd1;

   typedef enum logic [2:0] {
      REG_PROTOCOL_SELECT = 3'd0,
      REG_VLAN_MATCH      = 3'd1,
      REG_REQUIRED_FLAGS  = 3'd2,
      REG_PATTERN_BYTES   = 3'd3,
      REG_PATTERN_LENGTH  = 3'd4,
      REG_INVERT_MATCH    = 3'd5,
      REG_WINDOW_START    = 3'd6,
      REG_WINDOW_END      = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      SEL_ANY  = 2'd0,
      SEL_TCP  = 2'd1,
      SEL_UDP  = 2'd2,
      SEL_ICMP = 2'd3
   } proto_sel_type;

   typedef struct packed {
      logic [1:0]  protocol_select;
      logic [11:0] vlan_match;
      logic [5:0]  required_flags;
      logic [63:0] pattern_bytes;
      logic [3:0]  pattern_length;
      logic        invert_match;
      logic [10:0] window_start;
      logic [10:0] window_end;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [10:0] minute_of_day;
   } item_type;

   typedef struct packed {
      logic forward;
      logic in_window;
      logic rule_match;
   } result_type;

endpackage

>>> rtl/core/packet_rule_filter.sv
// Channel   Direction  Transfer                      Payload
// req_      in         one frame byte                tdata, tlast = last_byte
// rsp_      out        one verdict per frame         tdata
// csr_      in/out     one register write or read    pwdata, prdata
//
// A byte is taken into the input register and parsed there; if it ends the frame,
// its verdict is loaded into the result register, which raises rsp_tvalid, as soon
// as that register is free or rsp_tready is high. One byte is accepted every cycle
// while no last byte is held back.
// Reset clears all frame state, the configuration registers and both valid flags.
// Only a last byte waits when the result register is full and rsp_tready is low.
`include "packet_rule_filter_assert.svh"

module packet_rule_filter (
   input  logic                              clock,
   input  logic                              reset,
   // Input stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // data_byte[7:0], minute_of_day[18:8]
   input  logic                              req_tlast,
   // Result stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,  // forward[0], in_window[1], rule_match[2]
   // Register port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [prf_pkg::CfgAddrBits-1:0]   csr_paddr,
   input  logic [prf_pkg::CfgDataBits-1:0]   csr_pwdata,
   output logic [prf_pkg::CfgDataBits-1:0]   csr_prdata,
   output logic                              csr_pready
);

   prf_pkg::cfg_type    cfg;
   prf_pkg::item_type   in_item_ff, in_item_in;
   logic                in_valid_ff, in_valid_in;
   prf_pkg::result_type out_result_ff, out_result_in;
   logic                out_valid_ff, out_valid_in;
   prf_pkg::result_type result;
   logic                advance;
   logic                req_xfer;

   assign csr_pready = 1'b1;

   prf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   // The held byte moves on unless it ends a frame and the verdict cannot be stored.
   assign advance    = in_valid_ff && (!in_item_ff.last_byte || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   prf_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_xfer) begin
         in_valid_in              = 1'b1;
         in_item_in.data_byte     = req_tdata[7:0];
         in_item_in.last_byte     = req_tlast;
         in_item_in.minute_of_day = req_tdata[18:8];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      if (advance && in_item_ff.last_byte) begin
         out_valid_in  = 1'b1;
         out_result_in = result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff    <= in_item_in;
      out_result_ff <= out_result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, out_result_ff.rule_match, out_result_ff.in_window,
                        out_result_ff.forward};

   // A forwarded frame must both match and lie inside the time window.
   `PRF_ASSERT_NOW(a_forward_consistent, clock, reset,
      out_valid_ff && out_result_ff.forward,
      out_result_ff.in_window && out_result_ff.rule_match,
      "forward set without match and window")

   // An accepted byte is always held in the input register next cycle.
   `PRF_ASSERT_NEXT(a_accept_held, clock, reset, req_xfer, in_valid_ff,
      "accepted byte lost")

   // The input register only stalls behind a blocked verdict.
   `PRF_ASSERT_NOW(a_stall_cause, clock, reset, in_valid_ff && !advance,
      in_item_ff.last_byte && out_valid_ff && !rsp_tready,
      "input stalled without output backpressure")

endmodule

>>> rtl/core/prf_csr.sv
module prf_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [prf_pkg::CfgAddrBits-1:0]    csr_paddr,
   input  logic [prf_pkg::CfgDataBits-1:0]    csr_pwdata,
   output logic [prf_pkg::CfgDataBits-1:0]    csr_prdata,
   output prf_pkg::cfg_type                   cfg
);

   prf_pkg::cfg_type       cfg_ff, cfg_in;
   prf_pkg::reg_index_type index;
   logic                   write_en;

   assign index    = prf_pkg::reg_index_type'(csr_paddr[prf_pkg::CfgAddrBits-1:3]);
   assign write_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            prf_pkg::REG_PROTOCOL_SELECT: cfg_in.protocol_select = csr_pwdata[1:0];
            prf_pkg::REG_VLAN_MATCH:      cfg_in.vlan_match      = csr_pwdata[11:0];
            prf_pkg::REG_REQUIRED_FLAGS:  cfg_in.required_flags  = csr_pwdata[5:0];
            prf_pkg::REG_PATTERN_BYTES:   cfg_in.pattern_bytes   = csr_pwdata[63:0];
            prf_pkg::REG_PATTERN_LENGTH:  cfg_in.pattern_length  = csr_pwdata[3:0];
            prf_pkg::REG_INVERT_MATCH:    cfg_in.invert_match    = csr_pwdata[0];
            prf_pkg::REG_WINDOW_START:    cfg_in.window_start    = csr_pwdata[10:0];
            prf_pkg::REG_WINDOW_END:      cfg_in.window_end      = csr_pwdata[10:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         prf_pkg::REG_PROTOCOL_SELECT: csr_prdata = 64'(cfg_ff.protocol_select);
         prf_pkg::REG_VLAN_MATCH:      csr_prdata = 64'(cfg_ff.vlan_match);
         prf_pkg::REG_REQUIRED_FLAGS:  csr_prdata = 64'(cfg_ff.required_flags);
         prf_pkg::REG_PATTERN_BYTES:   csr_prdata = cfg_ff.pattern_bytes;
         prf_pkg::REG_PATTERN_LENGTH:  csr_prdata = 64'(cfg_ff.pattern_length);
         prf_pkg::REG_INVERT_MATCH:    csr_prdata = 64'(cfg_ff.invert_match);
         prf_pkg::REG_WINDOW_START:    csr_prdata = 64'(cfg_ff.window_start);
         prf_pkg::REG_WINDOW_END:      csr_prdata = 64'(cfg_ff.window_end);
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/prf_parse.sv
module prf_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  prf_pkg::item_type    item,
   input  prf_pkg::cfg_type     cfg,
   output prf_pkg::result_type  result
);

   localparam int OB = prf_pkg::OffsetBits;
   localparam int PB = prf_pkg::PayEndBits;

   logic [OB-1:0] offset_ff,  offset_in;
   logic [3:0]    ihl_ff,     ihl_in;
   logic [15:0]   total_ff,   total_in;
   logic [7:0]    proto_ff,   proto_in;
   logic [15:0]   tag_ff,     tag_in;
   logic [3:0]    thw_ff,     thw_in;
   logic [5:0]    flags_ff,   flags_in;
   logic [63:0]   recent_ff,  recent_in;
   logic [OB-1:0] seen_ff,    seen_in;
   logic          found_ff,   found_in;

   logic [7:0]    b;
   logic [OB-1:0] tcp_start;
   logic [OB-1:0] pay_start;
   logic [PB-1:0] pay_end;
   logic          in_payload;
   logic [3:0]    len;
   logic          hit;
   logic [2:0]    pat_idx;
   logic          match;
   logic          proto_ok;

   always_comb begin
      b        = item.data_byte;
      ihl_in   = ihl_ff;
      tag_in   = tag_ff;
      total_in = total_ff;
      proto_in = proto_ff;

      if (offset_ff == OB'(prf_pkg::EthHdrLen)) begin
         ihl_in = b[3:0];
         tag_in = {b, tag_ff[7:0]};
      end else if (offset_ff == OB'(prf_pkg::EthHdrLen) + OB'(1)) begin
         tag_in = {tag_ff[15:8], b};
      end else if (offset_ff == OB'(prf_pkg::EthHdrLen) + OB'(2)) begin
         total_in = {b, total_ff[7:0]};
      end else if (offset_ff == OB'(prf_pkg::EthHdrLen) + OB'(3)) begin
         total_in = {total_ff[15:8], b};
      end else if (offset_ff == OB'(prf_pkg::EthHdrLen) + OB'(9)) begin
         proto_in = b;
      end

      tcp_start = OB'(prf_pkg::EthHdrLen) + OB'({ihl_in, 2'b00});
      thw_in    = (offset_ff == tcp_start + OB'(12)) ? b[7:4] : thw_ff;
      flags_in  = (offset_ff == tcp_start + OB'(13)) ? b[5:0] : flags_ff;
      recent_in = {recent_ff[55:0], b};

      pay_start  = tcp_start + OB'({thw_in, 2'b00});
      pay_end    = PB'(prf_pkg::EthHdrLen) + PB'(total_in);
      in_payload = (offset_ff > tcp_start + OB'(12)) && (offset_ff >= pay_start)
                   && (PB'(offset_ff) < pay_end);

      seen_in = seen_ff;
      if (in_payload && (seen_ff != '1)) begin
         seen_in = seen_ff + OB'(1);
      end

      len = (cfg.pattern_length > 4'(prf_pkg::PatternMax)) ?
            4'(prf_pkg::PatternMax) : cfg.pattern_length;

      // Byte k back from the newest must equal pattern byte len-1-k.
      hit = 1'b1;
      for (int k = 0; k < prf_pkg::PatternMax; k++) begin
         pat_idx = 3'(len - 4'(k) - 4'd1);
         if ((4'(k) < len) &&
             (recent_in[8*k +: 8] != cfg.pattern_bytes[{3'd7 - pat_idx, 3'b000} +: 8])) begin
            hit = 1'b0;
         end
      end

      found_in = found_ff | (in_payload && (len != 4'd0) && (seen_in >= OB'(len)) && hit);

      offset_in = (offset_ff != '1) ? offset_ff + OB'(1) : offset_ff;

      case (prf_pkg::proto_sel_type'(cfg.protocol_select))
         prf_pkg::SEL_ANY:  proto_ok = 1'b1;
         prf_pkg::SEL_TCP:  proto_ok = (proto_in == prf_pkg::ProtoTcp);
         prf_pkg::SEL_UDP:  proto_ok = (proto_in == prf_pkg::ProtoUdp);
         prf_pkg::SEL_ICMP: proto_ok = (proto_in == prf_pkg::ProtoIcmp);
         default:           proto_ok = 1'b1;
      endcase

      match = proto_ok
              && ((cfg.vlan_match == 12'd0) ||
                  ((tag_in[11:0] & prf_pkg::VlanMask) == cfg.vlan_match))
              && ((flags_in & cfg.required_flags) == cfg.required_flags)
              && ((len == 4'd0) || found_in);

      result.rule_match = match ^ cfg.invert_match;
      if (cfg.window_start < cfg.window_end) begin
         result.in_window = (item.minute_of_day >= cfg.window_start) &&
                            (item.minute_of_day <= cfg.window_end);
      end else begin
         result.in_window = (item.minute_of_day >= cfg.window_start) ||
                            (item.minute_of_day <= cfg.window_end);
      end
      result.forward = result.rule_match && result.in_window;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last_byte)) begin
         offset_ff <= '0;
         ihl_ff    <= '0;
         total_ff  <= '0;
         proto_ff  <= '0;
         tag_ff    <= '0;
         thw_ff    <= '0;
         flags_ff  <= '0;
         recent_ff <= '0;
         seen_ff   <= '0;
         found_ff  <= 1'b0;
      end else if (step) begin
         offset_ff <= offset_in;
         ihl_ff    <= ihl_in;
         total_ff  <= total_in;
         proto_ff  <= proto_in;
         tag_ff    <= tag_in;
         thw_ff    <= thw_in;
         flags_ff  <= flags_in;
         recent_ff <= recent_in;
         seen_ff   <= seen_in;
         found_ff  <= found_in;
      end
   end

endmodule

>>> tb/sv/packet_rule_filter_checker.sv
`timescale 1ns / 1ps

module packet_rule_filter_checker
   import prf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [23:0]            req_tdata,  // data_byte[7:0], minute_of_day[18:8]
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [7:0]             rsp_tdata,  // forward[0], in_window[1], rule_match[2]
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CfgAddrBits-1:0] csr_paddr,
   input  logic [CfgDataBits-1:0] csr_pwdata,
   input  logic [CfgDataBits-1:0] csr_prdata,
   input  logic                   csr_pready,
   output int unsigned            failures,
   output int unsigned            pending
);

   cfg_type     rule_cfg;
   logic [10:0] at_offset;
   logic [3:0]  ihl;
   logic [15:0] ip_len;
   logic [7:0]  ip_proto;
   logic [15:0] tag;
   logic [3:0]  tcp_doff;
   logic [5:0]  seen_flags;
   logic [63:0] byte_history;
   logic [10:0] payload_count;
   logic        pattern_seen;

   result_type  verdict_queue[$];
   result_type  want;
   logic [63:0] read_expect;

   task automatic clear_frame_state();
      at_offset     = '0;
      ihl           = '0;
      ip_len        = '0;
      ip_proto      = '0;
      tag           = '0;
      tcp_doff      = '0;
      seen_flags    = '0;
      byte_history  = '0;
      payload_count = '0;
      pattern_seen  = 1'b0;
   endtask

   // Follows one accepted frame byte and queues a verdict when it ends the frame.
   task automatic absorb_byte(input logic [7:0] value, input logic final_byte,
                              input logic [10:0] minute);
      int          off;
      int          tcp_start;
      int          pay_start;
      int          pay_end;
      int          plen;
      logic [63:0] mask;
      logic [63:0] expected_tail;
      logic        matched;
      logic        timely;
      result_type  verdict;
      off = int'(at_offset);
      if (off == int'(EthHdrLen)) begin
         ihl = value[3:0];
         tag = {value, tag[7:0]};
      end else if (off == int'(EthHdrLen) + 1) begin
         tag = {tag[15:8], value};
      end else if (off == int'(EthHdrLen) + 2) begin
         ip_len = {value, ip_len[7:0]};
      end else if (off == int'(EthHdrLen) + 3) begin
         ip_len = {ip_len[15:8], value};
      end else if (off == int'(EthHdrLen) + 9) begin
         ip_proto = value;
      end
      tcp_start = int'(EthHdrLen) + 4 * int'(ihl);
      if (off == tcp_start + 12) tcp_doff = value[7:4];
      if (off == tcp_start + 13) seen_flags = value[5:0];
      byte_history = {byte_history[55:0], value};
      pay_start = tcp_start + 4 * int'(tcp_doff);
      pay_end   = int'(EthHdrLen) + int'(ip_len);
      if (off > tcp_start + 12 && off >= pay_start && off < pay_end) begin
         if (payload_count != '1) payload_count++;
         plen = (int'(rule_cfg.pattern_length) > PatternMax) ? PatternMax
                                                              : int'(rule_cfg.pattern_length);
         if (plen != 0 && int'(payload_count) >= plen) begin
            mask          = (plen >= 8) ? '1 : ((64'd1 << (8 * plen)) - 64'd1);
            expected_tail = rule_cfg.pattern_bytes >> (64 - 8 * plen);
            if ((byte_history & mask) == expected_tail) pattern_seen = 1'b1;
         end
      end
      if (at_offset != '1) at_offset++;
      if (final_byte) begin
         matched = 1'b1;
         case (proto_sel_type'(rule_cfg.protocol_select))
            SEL_TCP:  if (ip_proto != ProtoTcp) matched = 1'b0;
            SEL_UDP:  if (ip_proto != ProtoUdp) matched = 1'b0;
            SEL_ICMP: if (ip_proto != ProtoIcmp) matched = 1'b0;
            default: ;
         endcase
         if (rule_cfg.vlan_match != 0 && (tag[11:0] & VlanMask) != rule_cfg.vlan_match)
            matched = 1'b0;
         if ((seen_flags & rule_cfg.required_flags) != rule_cfg.required_flags) matched = 1'b0;
         if (rule_cfg.pattern_length != 0 && !pattern_seen) matched = 1'b0;
         if (rule_cfg.invert_match) matched = !matched;
         if (rule_cfg.window_start < rule_cfg.window_end)
            timely = minute >= rule_cfg.window_start && minute <= rule_cfg.window_end;
         else
            timely = minute >= rule_cfg.window_start || minute <= rule_cfg.window_end;
         verdict.forward    = matched && timely;
         verdict.in_window  = timely;
         verdict.rule_match = matched;
         verdict_queue.push_back(verdict);
         clear_frame_state();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rule_cfg = '0;
         clear_frame_state();
         verdict_queue.delete();
         failures = 0;
         pending  = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (reg_index_type'(csr_paddr[CfgAddrBits-1:3]))
                  REG_PROTOCOL_SELECT: rule_cfg.protocol_select = csr_pwdata[1:0];
                  REG_VLAN_MATCH:      rule_cfg.vlan_match      = csr_pwdata[11:0];
                  REG_REQUIRED_FLAGS:  rule_cfg.required_flags  = csr_pwdata[5:0];
                  REG_PATTERN_BYTES:   rule_cfg.pattern_bytes   = csr_pwdata;
                  REG_PATTERN_LENGTH:  rule_cfg.pattern_length  = csr_pwdata[3:0];
                  REG_INVERT_MATCH:    rule_cfg.invert_match    = csr_pwdata[0];
                  REG_WINDOW_START:    rule_cfg.window_start    = csr_pwdata[10:0];
                  REG_WINDOW_END:      rule_cfg.window_end      = csr_pwdata[10:0];
                  default: ;
               endcase
            end else begin
               case (reg_index_type'(csr_paddr[CfgAddrBits-1:3]))
                  REG_PROTOCOL_SELECT: read_expect = 64'(rule_cfg.protocol_select);
                  REG_VLAN_MATCH:      read_expect = 64'(rule_cfg.vlan_match);
                  REG_REQUIRED_FLAGS:  read_expect = 64'(rule_cfg.required_flags);
                  REG_PATTERN_BYTES:   read_expect = rule_cfg.pattern_bytes;
                  REG_PATTERN_LENGTH:  read_expect = 64'(rule_cfg.pattern_length);
                  REG_INVERT_MATCH:    read_expect = 64'(rule_cfg.invert_match);
                  REG_WINDOW_START:    read_expect = 64'(rule_cfg.window_start);
                  default:             read_expect = 64'(rule_cfg.window_end);
               endcase
               if (csr_prdata !== read_expect) begin
                  $error("csr_prdata: expected %0h, actual %0h", read_expect, csr_prdata);
                  failures++;
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_queue.size() == 0) begin
               $error("verdict transfer with none pending: actual %0h", rsp_tdata);
               failures++;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_tdata[0] !== want.forward) begin
                  $error("forward: expected %0b, actual %0b", want.forward, rsp_tdata[0]);
                  failures++;
               end
               if (rsp_tdata[1] !== want.in_window) begin
                  $error("in_window: expected %0b, actual %0b", want.in_window, rsp_tdata[1]);
                  failures++;
               end
               if (rsp_tdata[2] !== want.rule_match) begin
                  $error("rule_match: expected %0b, actual %0b", want.rule_match, rsp_tdata[2]);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) absorb_byte(req_tdata[7:0], req_tlast, req_tdata[18:8]);
         pending = verdict_queue.size();
      end
   end

endmodule

>>> tb/sv/packet_rule_filter_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the packet rule filter. The checker instance beside the
// block does all prediction and comparison; this module only shapes frames, programs
// the rule between phases and decides pass or fail from the checker's counts.
module packet_rule_filter_test;
   import prf_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [23:0]            req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [7:0]             rsp_tdata;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CfgAddrBits-1:0] csr_paddr;
   logic [CfgDataBits-1:0] csr_pwdata;
   logic [CfgDataBits-1:0] csr_prdata;
   logic                   csr_pready;
   int unsigned            failures;
   int unsigned            pending;

   // When calm is set, neither side inserts idle cycles.
   bit                     calm = 1'b0;
   // Rule that apply_plan programs, also used to steer frames toward matches.
   cfg_type                plan;
   logic [7:0]             frame_bytes[$];

   always #5 clock = ~clock;

   packet_rule_filter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   packet_rule_filter_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .pending     (pending)
   );

   // One register transfer: a setup phase, then an access phase that completes on
   // pready. The bus is left selected so that a following transfer can start in the
   // very next cycle without driving psel twice in one time step.
   task automatic csr_access(input reg_index_type index, input logic write,
                             input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CfgAddrBits'({index, 3'd0});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // Writes every register from the plan and reads each one back for the checker.
   task automatic apply_plan();
      logic [63:0] values[8];
      values[0] = 64'(plan.protocol_select);
      values[1] = 64'(plan.vlan_match);
      values[2] = 64'(plan.required_flags);
      values[3] = plan.pattern_bytes;
      values[4] = 64'(plan.pattern_length);
      values[5] = 64'(plan.invert_match);
      values[6] = 64'(plan.window_start);
      values[7] = 64'(plan.window_end);
      for (int r = 0; r < 8; r++) begin
         csr_access(reg_index_type'(r), 1'b1, values[r]);
         csr_access(reg_index_type'(r), 1'b0, 64'd0);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Offers one byte and holds it until the transfer completes. An optional idle
   // burst goes in front, so gaps can land at any offset of the frame.
   task automatic send_byte(input logic [7:0] value, input logic final_byte,
                            input logic [10:0] minute);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, minute, value};
      req_tlast  <= final_byte;
      do @(posedge clock); while (!req_tready);
   endtask

   // Sends the frame in frame_bytes. The minute on the last byte decides the time
   // window; a negative argument picks one at the window bounds, the extremes or at random.
   task automatic send_frame(input int finish_minute);
      int minute;
      int count;
      minute = finish_minute;
      if (minute < 0) begin
         case ($urandom_range(0, 7))
            0: minute = 0;
            1: minute = 1439;
            2: minute = 2047;
            3: minute = int'(plan.window_start);
            4: minute = int'(plan.window_end);
            5: minute = int'(plan.window_start) - 1;
            6: minute = int'(plan.window_end) + 1;
            default: minute = $urandom_range(0, 2047);
         endcase
      end
      count = frame_bytes.size();
      for (int i = 0; i < count; i++)
         send_byte(frame_bytes[i], i == count - 1,
                   (i == count - 1) ? 11'(minute) : 11'($urandom_range(0, 2047)));
   endtask

   // Builds one frame. Some are short random noise with no header built in. The
   // rest carry an IPv4 and TCP header with random content, and most of those are
   // steered to satisfy the programmed rule so that the deep checks get exercised.
   task automatic build_frame();
      int         len;
      int         ihl;
      int         doff;
      int         tcp_start;
      int         pay_begin;
      int         pay_len;
      int         pad;
      int         total;
      int         plen;
      int         pos;
      logic [7:0] proto;
      bit         conform;
      frame_bytes.delete();
      if ($urandom_range(0, 9) < 4) begin
         len = $urandom_range(1, 30);
         repeat (len) frame_bytes.push_back(8'($urandom));
      end else begin
         conform = ($urandom_range(0, 9) < 7);
         // The VLAN value shares its top nibble with the IHL field of byte 14.
         if (conform && plan.vlan_match != 0) ihl = int'(plan.vlan_match[11:8]);
         else if ($urandom_range(0, 3) == 0) ihl = $urandom_range(0, 15);
         else ihl = 5;
         doff      = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
         tcp_start = 14 + 4 * ihl;
         pay_begin = tcp_start + 4 * doff;
         if (pay_begin < tcp_start + 13) pay_begin = tcp_start + 13;
         pay_len   = $urandom_range(0, 16);
         pad       = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
         len       = pay_begin + pay_len;
         if (len < 24) len = 24;
         len   = len + pad;
         total = len - pad - 14;
         if ($urandom_range(0, 7) == 0) total = $urandom_range(0, 65535);
         repeat (len) frame_bytes.push_back(8'($urandom));
         frame_bytes[14] = {4'($urandom), 4'(ihl)};
         if (conform && plan.vlan_match != 0) frame_bytes[15] = plan.vlan_match[7:0];
         frame_bytes[16] = total[15:8];
         frame_bytes[17] = total[7:0];
         case ($urandom_range(0, 3))
            0: proto = ProtoTcp;
            1: proto = ProtoUdp;
            2: proto = ProtoIcmp;
            default: proto = 8'($urandom);
         endcase
         if (conform) begin
            case (proto_sel_type'(plan.protocol_select))
               SEL_TCP:  proto = ProtoTcp;
               SEL_UDP:  proto = ProtoUdp;
               SEL_ICMP: proto = ProtoIcmp;
               default: ;
            endcase
         end
         frame_bytes[23] = proto;
         if (tcp_start + 13 < len) begin
            frame_bytes[tcp_start + 12] = {4'(doff), 4'($urandom)};
            frame_bytes[tcp_start + 13] = {2'($urandom),
               6'($urandom) | (conform ? plan.required_flags : 6'd0)};
         end
         // Place the pattern inside the payload, or straddling its first byte so
         // that only a partial copy lies in the payload.
         plen = (plan.pattern_length > PatternMax) ? PatternMax : int'(plan.pattern_length);
         pos  = -1;
         if (plen != 0) begin
            if (conform && pay_len >= plen)
               pos = $urandom_range(pay_begin, pay_begin + pay_len - plen);
            else if ($urandom_range(0, 1) == 0 && pay_begin + plen <= len)
               pos = pay_begin - 1;
         end
         if (pos >= 0) begin
            for (int k = 0; k < plen; k++)
               frame_bytes[pos + k] = plan.pattern_bytes[63 - 8 * k -: 8];
         end
      end
   endtask

   // Drops the input valid and waits until every verdict has come back, then lets
   // the two-stage pipeline drain fully. The count is sampled on the falling edge,
   // once the checker has updated it.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Result side: ready in random stretches broken by stall bursts, steady when calm.
   initial begin
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
         if (!calm) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
      end
   end

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      plan        = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset rule, whose equal window bounds keep the
      // window always open: one-byte frames at the time extremes, then a short
      // frame of all-ones bytes whose header never reaches the TCP fields.
      frame_bytes = '{8'h00};
      send_frame(0);
      frame_bytes = '{8'hFF};
      send_frame(2047);
      frame_bytes = '{8'h5A};
      send_frame(1439);
      frame_bytes.delete();
      repeat (22) frame_bytes.push_back(8'hFF);
      send_frame(-1);
      settle();

      // Random phases, each with its own rule. The first two use the largest and
      // the smallest register values; the last one runs without idle cycles.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               plan.protocol_select = SEL_ICMP;
               plan.vlan_match      = 12'hFFF;
               plan.required_flags  = 6'h3F;
               plan.pattern_bytes   = '1;
               plan.pattern_length  = 4'hF;
               plan.invert_match    = 1'b1;
               plan.window_start    = 11'd1439;
               plan.window_end      = 11'd0;
            end
            1: begin
               plan            = '0;
               plan.window_end = 11'd1439;
            end
            default: begin
               plan.protocol_select = 2'($urandom_range(0, 3));
               plan.vlan_match      = ($urandom_range(0, 1) == 0) ? 12'd0
                                                                 : 12'($urandom_range(1, 4095));
               plan.required_flags  = ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom);
               plan.pattern_bytes   = {$urandom, $urandom};
               plan.pattern_length  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                                 : 4'($urandom_range(0, 8));
               plan.invert_match    = 1'($urandom);
               case ($urandom_range(0, 4))
                  0: begin
                     plan.window_start = 11'($urandom_range(0, 1439));
                     plan.window_end   = plan.window_start;
                  end
                  1: begin
                     plan.window_start = 11'($urandom_range(0, 1439));
                     plan.window_end   = 11'($urandom_range(0, 1439));
                  end
                  2: begin
                     plan.window_start = 11'($urandom_range(0, 700));
                     plan.window_end   = 11'($urandom_range(plan.window_start + 1, 1439));
                  end
                  3: begin
                     plan.window_start = 11'($urandom_range(700, 1439));
                     plan.window_end   = 11'($urandom_range(0, plan.window_start - 1));
                  end
                  default: begin
                     plan.window_start = 11'($urandom_range(0, 2047));
                     plan.window_end   = 11'($urandom_range(0, 2047));
                  end
               endcase
            end
         endcase
         apply_plan();
         calm = (phase == 7);
         for (int f = 0; f < 3; f++) begin
            build_frame();
            send_frame(-1);
         end
         settle();
      end

      if (failures == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog for a stalled handshake or a verdict that never arrives.
   initial begin
      #8_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/prf_pkg.sv
rtl/core/prf_csr.sv
rtl/core/prf_parse.sv
rtl/core/packet_rule_filter.sv
tb/sv/packet_rule_filter_checker.sv
tb/sv/packet_rule_filter_test.sv
